// ===== hw/rtl/dmc_pkg.sv =====
// Shared types, codes and the rate table of the delta-modulation sample channel.
// No dependencies; every other file of the block imports this package.
package dmc_pkg;

    // Request kinds as they arrive in the input tuser field.
    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_ENABLE    = 3'd1;
    localparam logic [2:0] REQ_LOAD      = 3'd2;
    localparam logic [2:0] REQ_BYTE      = 3'd3;
    localparam logic [2:0] REQ_IRQ_CLEAR = 3'd4;

    // Command kinds after classification in the front end.
    localparam logic [2:0] CMD_NOP       = 3'd0;
    localparam logic [2:0] CMD_TICK      = 3'd1;
    localparam logic [2:0] CMD_ENABLE    = 3'd2;
    localparam logic [2:0] CMD_LOAD      = 3'd3;
    localparam logic [2:0] CMD_BYTE      = 3'd4;
    localparam logic [2:0] CMD_IRQ_CLEAR = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_IRQ_ENABLE  = 3'd0;
    localparam logic [2:0] CFG_LOOP_ENABLE = 3'd1;
    localparam logic [2:0] CFG_RATE_INDEX  = 3'd2;
    localparam logic [2:0] CFG_SAMPLE_ADDR = 3'd3;
    localparam logic [2:0] CFG_SAMPLE_LEN  = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Address map constants.
    localparam logic [15:0] SAMPLE_BASE = 16'hC000;
    localparam logic [15:0] WRAP_ADDR   = 16'h8000;
    localparam logic [15:0] LAST_ADDR   = 16'hFFFF;
    localparam logic [6:0]  LEVEL_MAX   = 7'd127;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    // One classified item as it sits in the queue.
    typedef struct packed {
        logic [2:0]  kind;
        logic        enable_value;
        logic [6:0]  load_value;
        logic [15:0] fetch_addr;
        logic [7:0]  fetch_data;
    } t_cmd;

    // One result item; the last field sits in the lowest bits.
    typedef struct packed {
        logic        fetch_is_reload;
        logic [15:0] fetch_req_addr;
        logic        fetch_req;
        logic        active;
        logic        irq;
        logic [6:0]  level;
    } t_result;

    // Divider reload value (period minus one) for each rate index.
    function automatic logic [7:0] rate_reload(input logic [3:0] idx);
        logic [7:0] period;
        case (idx)
            4'd0:    period = 8'(428 / 2);
            4'd1:    period = 8'(380 / 2);
            4'd2:    period = 8'(340 / 2);
            4'd3:    period = 8'(320 / 2);
            4'd4:    period = 8'(286 / 2);
            4'd5:    period = 8'(254 / 2);
            4'd6:    period = 8'(226 / 2);
            4'd7:    period = 8'(214 / 2);
            4'd8:    period = 8'(190 / 2);
            4'd9:    period = 8'(160 / 2);
            4'd10:   period = 8'(142 / 2);
            4'd11:   period = 8'(128 / 2);
            4'd12:   period = 8'(106 / 2);
            4'd13:   period = 8'(84 / 2);
            4'd14:   period = 8'(72 / 2);
            default: period = 8'(54 / 2);
        endcase
        return period - 8'd1;
    endfunction

endpackage

// ===== hw/rtl/delta_modulation_sample_channel_core.sv =====
// Top level of the delta-modulation sample playback channel.
// Depends on dmc_pkg, dmc_front, dmc_queue and dmc_back.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser req_type, tdata operands
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata one result item
// cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// Every item yields one result. The back end executes one queued item per
// cycle while the output is not stalled, so the sustained rate is one item per
// clock. An accepted item is written into the queue and the back end then
// loads its result into the result register, which drives m_axis. Reset
// clears the queue, the result valid flag and all channel state. A stalled
// output holds the result and the queue absorbs up to QUEUE_DEPTH items before
// s_axis_tready falls.
module delta_modulation_sample_channel_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input items.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: enable_value[0], load_value[7:1], fetch_addr[23:8], fetch_data[31:24]
    input  logic [31:0]                    s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [2:0]                     s_axis_tuser,
    // Result items.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: level[6:0], irq[7], active[8], fetch_req[9], fetch_req_addr[25:10],
    //        fetch_is_reload[26], zero[31:27]
    output logic [31:0]                    m_axis_tdata
);
    import dmc_pkg::*;

    t_cmd    front_cmd, head_cmd;
    logic    head_valid, head_pop;
    t_result res;

    // Classify the incoming item.
    dmc_front u_front (
        .i_req_type     (s_axis_tuser),
        .i_enable_value (s_axis_tdata[0]),
        .i_load_value   (s_axis_tdata[7:1]),
        .i_fetch_addr   (s_axis_tdata[23:8]),
        .i_fetch_data   (s_axis_tdata[31:24]),
        .o_cmd          (front_cmd)
    );

    // Decouple acceptance from execution.
    dmc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_cmd   (front_cmd),
        .o_ready (s_axis_tready),
        .i_pop   (head_pop),
        .o_valid (head_valid),
        .o_head  (head_cmd)
    );

    // Execute commands and hold the result.
    dmc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (head_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {5'b00000, res};

endmodule

// ===== hw/rtl/dmc_front.sv =====
// Front end: decodes the request kind of an incoming item into a queue command.
// Depends on dmc_pkg.
module dmc_front (
    input  logic [2:0]     i_req_type,
    input  logic           i_enable_value,
    input  logic [6:0]     i_load_value,
    input  logic [15:0]    i_fetch_addr,
    input  logic [7:0]     i_fetch_data,
    output dmc_pkg::t_cmd  o_cmd
);
    import dmc_pkg::*;

    logic [2:0] kind;

    // Map request codes to command kinds; unknown codes become no-ops.
    always_comb begin
        case (i_req_type)
            REQ_TICK:      kind = CMD_TICK;
            REQ_ENABLE:    kind = CMD_ENABLE;
            REQ_LOAD:      kind = CMD_LOAD;
            REQ_BYTE:      kind = CMD_BYTE;
            REQ_IRQ_CLEAR: kind = CMD_IRQ_CLEAR;
            default:       kind = CMD_NOP;
        endcase
    end

    // Pack the command with its operands.
    assign o_cmd.kind         = kind;
    assign o_cmd.enable_value = i_enable_value;
    assign o_cmd.load_value   = i_load_value;
    assign o_cmd.fetch_addr   = i_fetch_addr;
    assign o_cmd.fetch_data   = i_fetch_data;

endmodule

// ===== hw/rtl/dmc_queue.sv =====
// Short command queue between the front end and the execution back end.
// Depends on dmc_pkg for the command type.
module dmc_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dmc_pkg::t_cmd  i_cmd,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output dmc_pkg::t_cmd  o_head
);
    import dmc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointer and count bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/dmc_back.sv =====
// Back end: channel state, configuration registers and the result register.
// Depends on dmc_pkg for command, result types and the rate table.
module dmc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dmc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_cmd_valid,
    input  dmc_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    output logic                          o_res_valid,
    output dmc_pkg::t_result              o_res,
    input  logic                          i_res_ready
);
    import dmc_pkg::*;

    // Configuration registers.
    logic       r_irq_enable, r_loop_enable;
    logic [3:0] r_rate_index;
    logic [7:0] r_sample_addr_code, r_sample_length_code;

    // Channel state.
    logic [7:0]  r_shift_reg, n_shift_reg;
    logic [3:0]  r_bits_left, n_bits_left;
    logic [6:0]  r_out_level, n_out_level;
    logic        r_silent, n_silent;
    logic [7:0]  r_buffer_byte, n_buffer_byte;
    logic        r_buffer_empty, n_buffer_empty;
    logic [15:0] r_cur_addr, n_cur_addr;
    logic [11:0] r_bytes_left, n_bytes_left;
    logic        r_irq_flag, n_irq_flag;
    logic [7:0]  r_divider_count, n_divider_count;

    // Result register.
    logic    r_res_valid;
    t_result r_res, n_res;

    logic [15:0] start_addr;
    logic [11:0] start_len;
    logic [3:0]  bits_dec;
    logic        fetch_req, fetch_reload;
    logic [15:0] fetch_addr;

    // Take a command whenever the result register is free or being emptied.
    assign o_pop       = i_cmd_valid && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign start_addr = SAMPLE_BASE + {2'b00, r_sample_addr_code, 6'b000000};
    assign start_len  = {r_sample_length_code, 4'b0000} + 12'd1;
    assign bits_dec   = r_bits_left - 4'd1;

    // Execute the head command against the current state.
    always_comb begin
        n_shift_reg     = r_shift_reg;
        n_bits_left     = r_bits_left;
        n_out_level     = r_out_level;
        n_silent        = r_silent;
        n_buffer_byte   = r_buffer_byte;
        n_buffer_empty  = r_buffer_empty;
        n_cur_addr      = r_cur_addr;
        n_bytes_left    = r_bytes_left;
        n_irq_flag      = r_irq_flag;
        n_divider_count = r_divider_count;
        fetch_req       = 1'b0;
        fetch_reload    = 1'b0;
        fetch_addr      = '0;
        case (i_cmd.kind)
            CMD_TICK: begin
                if (r_divider_count == 8'd0) begin
                    n_divider_count = rate_reload(r_rate_index);
                    if (!r_silent) begin
                        if (r_shift_reg[0]) begin
                            if (r_out_level <= LEVEL_MAX - 7'd2) begin
                                n_out_level = r_out_level + 7'd2;
                            end
                        end else if (r_out_level >= 7'd2) begin
                            n_out_level = r_out_level - 7'd2;
                        end
                    end
                    n_shift_reg = {1'b0, r_shift_reg[7:1]};
                    n_bits_left = bits_dec;
                    // End of an output cycle: reload from the buffer or fall silent.
                    if (bits_dec == 4'd0) begin
                        n_bits_left = BITS_PER_BYTE;
                        if (r_buffer_empty) begin
                            n_silent = 1'b1;
                        end else begin
                            n_silent       = 1'b0;
                            n_shift_reg    = r_buffer_byte;
                            n_buffer_empty = 1'b1;
                            if (r_bytes_left != 12'd0) begin
                                fetch_req    = 1'b1;
                                fetch_addr   = r_cur_addr;
                                fetch_reload = 1'b1;
                            end
                        end
                    end
                end else begin
                    n_divider_count = r_divider_count - 8'd1;
                end
            end
            CMD_ENABLE: begin
                if (!i_cmd.enable_value) begin
                    n_bytes_left = '0;
                end else if (r_bytes_left == 12'd0) begin
                    // The restart length is never zero, so only the buffer matters.
                    n_cur_addr   = start_addr;
                    n_bytes_left = start_len;
                    if (r_buffer_empty) begin
                        fetch_req  = 1'b1;
                        fetch_addr = start_addr;
                    end
                end
            end
            CMD_LOAD: begin
                n_out_level = i_cmd.load_value;
            end
            CMD_BYTE: begin
                if (i_cmd.fetch_addr == r_cur_addr && r_bytes_left != 12'd0) begin
                    n_buffer_byte  = i_cmd.fetch_data;
                    n_buffer_empty = 1'b0;
                    n_cur_addr     = (r_cur_addr == LAST_ADDR) ? WRAP_ADDR
                                                               : r_cur_addr + 16'd1;
                    n_bytes_left   = r_bytes_left - 12'd1;
                    // Sample finished: loop or raise the interrupt.
                    if (r_bytes_left == 12'd1) begin
                        if (r_loop_enable) begin
                            n_cur_addr   = start_addr;
                            n_bytes_left = start_len;
                        end else if (r_irq_enable) begin
                            n_irq_flag = 1'b1;
                        end
                    end
                end
            end
            CMD_IRQ_CLEAR: begin
                n_irq_flag = 1'b0;
            end
            default: begin
            end
        endcase
        n_res.level           = n_out_level;
        n_res.irq             = n_irq_flag;
        n_res.active          = (n_bytes_left != 12'd0);
        n_res.fetch_req       = fetch_req;
        n_res.fetch_req_addr  = fetch_addr;
        n_res.fetch_is_reload = fetch_reload;
    end

    // State, configuration and result valid updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_enable         <= 1'b0;
            r_loop_enable        <= 1'b0;
            r_rate_index         <= '0;
            r_sample_addr_code   <= '0;
            r_sample_length_code <= '0;
            r_shift_reg          <= '0;
            r_bits_left          <= BITS_PER_BYTE;
            r_out_level          <= '0;
            r_silent             <= 1'b1;
            r_buffer_byte        <= '0;
            r_buffer_empty       <= 1'b1;
            r_cur_addr           <= '0;
            r_bytes_left         <= '0;
            r_irq_flag           <= 1'b0;
            r_divider_count      <= '0;
            r_res_valid          <= 1'b0;
        end else begin
            if (o_pop) begin
                r_shift_reg     <= n_shift_reg;
                r_bits_left     <= n_bits_left;
                r_out_level     <= n_out_level;
                r_silent        <= n_silent;
                r_buffer_byte   <= n_buffer_byte;
                r_buffer_empty  <= n_buffer_empty;
                r_cur_addr      <= n_cur_addr;
                r_bytes_left    <= n_bytes_left;
                r_irq_flag      <= n_irq_flag;
                r_divider_count <= n_divider_count;
                r_res_valid     <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            // The user must write configuration only while the channel is idle; the block itself does not enforce it.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IRQ_ENABLE: begin
                        r_irq_enable <= i_cfg_data[0];
                        if (!i_cfg_data[0]) begin
                            r_irq_flag <= 1'b0;
                        end
                    end
                    CFG_LOOP_ENABLE: r_loop_enable        <= i_cfg_data[0];
                    CFG_RATE_INDEX:  r_rate_index         <= i_cfg_data[3:0];
                    CFG_SAMPLE_ADDR: r_sample_addr_code   <= i_cfg_data;
                    CFG_SAMPLE_LEN:  r_sample_length_code <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    // The bit counter always lies between one and eight.
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bits_left >= 4'd1) && (r_bits_left <= BITS_PER_BYTE))
        else $error("bit counter out of range");

    // The interrupt flag is never set while interrupts are disabled.
    a_irq_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_irq_enable |-> !r_irq_flag)
        else $error("interrupt flag set while disabled");

    // A waiting result blocks the next command.
    a_stall_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_res_ready) |-> !o_pop)
        else $error("command taken while result stalled");

    // Without a fetch, its address and kind read as zero.
    a_fetch_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_res.fetch_req) |->
            (r_res.fetch_req_addr == 16'd0) && !r_res.fetch_is_reload)
        else $error("fetch fields set without a fetch");

    // A fetch, reload or start, is only issued while bytes remain.
    a_fetch_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.fetch_req) |-> r_res.active)
        else $error("fetch issued with no bytes left");

endmodule

// ===== dv/tb_delta_modulation_sample_channel_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for delta_modulation_sample_channel_core.
// Depends on dmc_pkg and the core. It predicts each result item from its own copy
// of the channel state and compares it on the output stream.
module tb_delta_modulation_sample_channel_core;

    import dmc_pkg::*;

    localparam int CLK_HALF = 10;

    // Request kinds that the channel has to ignore.
    localparam logic [2:0] REQ_RESERVED_LO = 3'd5;
    localparam logic [2:0] REQ_RESERVED_HI = 3'd7;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: enable_value[0], load_value[7:1], fetch_addr[23:8], fetch_data[31:24]
    logic [31:0]           s_axis_tdata  = '0;
    // tuser: req_type[2:0]
    logic [2:0]            s_axis_tuser  = REQ_TICK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: level[6:0], irq[7], active[8], fetch_req[9], fetch_req_addr[25:10],
    //        fetch_is_reload[26], zero[31:27]
    logic [31:0]           m_axis_tdata;

    delta_modulation_sample_channel_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Predicted channel state and register copies.
    logic [7:0]  shifter;
    logic [3:0]  bit_cnt;
    logic [6:0]  lvl;
    logic        muted;
    logic [7:0]  buf_byte;
    logic        buf_empty;
    logic [15:0] addr_ptr;
    logic [11:0] remaining;
    logic        irq_pend;
    logic [7:0]  div_cnt;
    logic        irq_en;
    logic        loop_en;
    logic [3:0]  rate_sel;
    logic [7:0]  addr_code;
    logic [7:0]  len_code;

    dmc_pkg::t_result expected_results[$];
    int               fail_count        = 0;
    bit               fetch_outstanding = 1'b0;
    bit               idle_on           = 1'b1;
    int               rx_hold           = 0;
    dmc_pkg::t_result want;
    dmc_pkg::t_result seen;

    // Divider period in ticks for each rate index.
    function automatic logic [7:0] divider_period(input logic [3:0] idx);
        case (idx)
            4'd0:    return 8'd214;
            4'd1:    return 8'd190;
            4'd2:    return 8'd170;
            4'd3:    return 8'd160;
            4'd4:    return 8'd143;
            4'd5:    return 8'd127;
            4'd6:    return 8'd113;
            4'd7:    return 8'd107;
            4'd8:    return 8'd95;
            4'd9:    return 8'd80;
            4'd10:   return 8'd71;
            4'd11:   return 8'd64;
            4'd12:   return 8'd53;
            4'd13:   return 8'd42;
            4'd14:   return 8'd36;
            default: return 8'd27;
        endcase
    endfunction

    function automatic logic [31:0] pack_ops(input logic en, input logic [6:0] load,
                                             input logic [15:0] addr, input logic [7:0] data);
        return {data, addr, load, en};
    endfunction

    // Random idle gap before the next item; no gap throughout a burst stretch.
    function automatic int draw_idle();
        return idle_on ? int'($urandom_range(0, 8)) : 0;
    endfunction

    // Levels near the saturation limits come up often.
    function automatic logic [6:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return 7'($urandom_range(0, 1));
            1:       return 7'($urandom_range(126, 127));
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic reset_model();
        shifter   = '0;
        bit_cnt   = BITS_PER_BYTE;
        lvl       = '0;
        muted     = 1'b1;
        buf_byte  = '0;
        buf_empty = 1'b1;
        addr_ptr  = '0;
        remaining = '0;
        irq_pend  = 1'b0;
        div_cnt   = '0;
        irq_en    = 1'b0;
        loop_en   = 1'b0;
        rate_sel  = '0;
        addr_code = '0;
        len_code  = '0;
    endtask

    task automatic restart_sample();
        addr_ptr  = SAMPLE_BASE + {2'b00, addr_code, 6'b000000};
        remaining = {len_code, 4'b0000} + 12'd1;
    endtask

    // Applies one accepted item to the predicted state and queues its result.
    task automatic advance_channel(input logic [2:0] req, input logic [31:0] ops);
        dmc_pkg::t_result res;
        res = '0;
        case (req)
            REQ_TICK: begin
                if (div_cnt == 8'd0) begin
                    div_cnt = divider_period(rate_sel) - 8'd1;
                    // Step the level by two while playing, clamped to 0..127.
                    if (!muted) begin
                        if (shifter[0]) begin
                            if (lvl <= LEVEL_MAX - 7'd2) lvl = lvl + 7'd2;
                        end else if (lvl >= 7'd2) begin
                            lvl = lvl - 7'd2;
                        end
                    end
                    shifter = shifter >> 1;
                    bit_cnt = bit_cnt - 4'd1;
                    // End of an output cycle: reload from the buffer or go silent.
                    if (bit_cnt == 4'd0) begin
                        bit_cnt = BITS_PER_BYTE;
                        if (buf_empty) begin
                            muted = 1'b1;
                        end else begin
                            muted     = 1'b0;
                            shifter   = buf_byte;
                            buf_empty = 1'b1;
                            if (remaining != 12'd0) begin
                                res.fetch_req       = 1'b1;
                                res.fetch_req_addr  = addr_ptr;
                                res.fetch_is_reload = 1'b1;
                            end
                        end
                    end
                end else begin
                    div_cnt = div_cnt - 8'd1;
                end
            end
            REQ_ENABLE: begin
                if (!ops[0]) begin
                    remaining = '0;
                end else if (remaining == 12'd0) begin
                    restart_sample();
                    if (buf_empty) begin
                        res.fetch_req      = 1'b1;
                        res.fetch_req_addr = addr_ptr;
                    end
                end
            end
            REQ_LOAD: lvl = ops[7:1];
            REQ_BYTE: begin
                // Only a byte for the current address is taken, and only while active.
                if (ops[23:8] == addr_ptr && remaining != 12'd0) begin
                    buf_byte  = ops[31:24];
                    buf_empty = 1'b0;
                    addr_ptr  = (addr_ptr == LAST_ADDR) ? WRAP_ADDR : addr_ptr + 16'd1;
                    remaining = remaining - 12'd1;
                    if (remaining == 12'd0) begin
                        if (loop_en) restart_sample();
                        else if (irq_en) irq_pend = 1'b1;
                    end
                end
            end
            REQ_IRQ_CLEAR: irq_pend = 1'b0;
            default: ;
        endcase
        if (res.fetch_req) fetch_outstanding = 1'b1;
        res.level  = lvl;
        res.irq    = irq_pend;
        res.active = (remaining != 12'd0);
        expected_results.push_back(res);
    endtask

    // Sends one item after a random gap and predicts its result once accepted.
    task automatic send_item(input logic [2:0] req, input logic [31:0] ops);
        int gap;
        if ($urandom_range(0, 29) == 0) idle_on = !idle_on;
        gap = draw_idle();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= ops;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_channel(req, ops);
    endtask

    // Stops sending and waits until every predicted result has been seen.
    task automatic wait_channel_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_IRQ_ENABLE: begin
                irq_en = value[0];
                if (!irq_en) irq_pend = 1'b0;
            end
            CFG_LOOP_ENABLE: loop_en   = value[0];
            CFG_RATE_INDEX:  rate_sel  = value[3:0];
            CFG_SAMPLE_ADDR: addr_code = value;
            CFG_SAMPLE_LEN:  len_code  = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic irq, input logic loop, input logic [3:0] rate,
                             input logic [7:0] addr, input logic [7:0] len);
        wait_channel_idle();
        set_register(CFG_IRQ_ENABLE, CFG_DATA_W'(irq));
        set_register(CFG_LOOP_ENABLE, CFG_DATA_W'(loop));
        set_register(CFG_RATE_INDEX, CFG_DATA_W'(rate));
        set_register(CFG_SAMPLE_ADDR, addr);
        set_register(CFG_SAMPLE_LEN, len);
    endtask

    // Tick, load, enable and byte requests, field extremes, dropped bytes and reserved kinds.
    task automatic test_basic_requests();
        send_item(REQ_TICK, '0);
        send_item(REQ_TICK, '1);
        send_item(REQ_LOAD, pack_ops(1'b0, 7'd127, 16'h0000, 8'h00));
        send_item(REQ_LOAD, pack_ops(1'b1, 7'd0, 16'hFFFF, 8'hFF));
        send_item(REQ_RESERVED_LO, '1);
        send_item(REQ_RESERVED_HI, '0);
        send_item(REQ_ENABLE, pack_ops(1'b0, 7'd127, 16'hFFFF, 8'hFF));
        // No bytes remain, so the return is dropped.
        send_item(REQ_BYTE, pack_ops(1'b0, 7'd0, 16'h0000, 8'hA5));
        send_item(REQ_ENABLE, pack_ops(1'b1, 7'd0, 16'h0000, 8'h00));
        // A second start while active changes nothing.
        send_item(REQ_ENABLE, pack_ops(1'b1, 7'd0, 16'h0000, 8'h00));
        send_item(REQ_BYTE, pack_ops(1'b0, 7'd0, 16'hFFFF, 8'h00));
        send_item(REQ_BYTE, pack_ops(1'b1, 7'd127, addr_ptr, 8'hFF));
        send_item(REQ_BYTE, pack_ops(1'b1, 7'd127, addr_ptr, 8'hFF));
    endtask

    // Interrupt set at the end of a sample, cleared by request and by disable.
    task automatic test_interrupt_flag();
        wait_channel_idle();
        set_register(CFG_IRQ_ENABLE, CFG_DATA_W'(1));
        send_item(REQ_ENABLE, pack_ops(1'b1, 7'd0, 16'h0000, 8'h00));
        send_item(REQ_BYTE, pack_ops(1'b0, 7'd0, addr_ptr, 8'h00));
        send_item(REQ_IRQ_CLEAR, '0);
        send_item(REQ_ENABLE, pack_ops(1'b1, 7'd0, 16'h0000, 8'h00));
        send_item(REQ_BYTE, pack_ops(1'b0, 7'd0, addr_ptr, 8'h5A));
        wait_channel_idle();
        set_register(CFG_IRQ_ENABLE, CFG_DATA_W'(0));
        send_item(REQ_TICK, '0);
        send_item(REQ_ENABLE, pack_ops(1'b1, 7'd0, 16'h0000, 8'h00));
        send_item(REQ_ENABLE, pack_ops(1'b0, 7'd0, 16'h0000, 8'h00));
    endtask

    // Sample at the top of memory runs past FFFF and continues at 8000.
    task automatic test_address_wrap();
        logic [31:0] ops;
        int          taken;
        configure(1'b0, 1'b1, 4'd15, 8'd255, 8'd8);
        send_item(REQ_ENABLE, pack_ops(1'b0, 7'd0, 16'h0000, 8'h00));
        send_item(REQ_ENABLE, pack_ops(1'b1, 7'd0, 16'h0000, 8'h00));
        taken = 0;
        while (taken < 72) begin
            ops = $urandom();
            if ($urandom_range(0, 2) != 0) begin
                ops[23:8] = addr_ptr;
                send_item(REQ_BYTE, ops);
                taken++;
            end else begin
                send_item(REQ_TICK, ops);
            end
        end
    endtask

    // Mostly ticks with byte returns answering fetch requests, plus noise.
    task automatic run_playback(input int n_items);
        logic [31:0] ops;
        int          pick;
        for (int i = 0; i < n_items; i++) begin
            ops  = $urandom();
            pick = $urandom_range(0, 99);
            if (fetch_outstanding && pick < 20) begin
                ops[23:8] = addr_ptr;
                fetch_outstanding = 1'b0;
                send_item(REQ_BYTE, ops);
            end else if (pick < 82) begin
                send_item(REQ_TICK, ops);
            end else if (pick < 86) begin
                ops[0] = ($urandom_range(0, 3) != 0);
                send_item(REQ_ENABLE, ops);
            end else if (pick < 90) begin
                ops[7:1] = pick_level();
                send_item(REQ_LOAD, ops);
            end else if (pick < 93) begin
                send_item(REQ_IRQ_CLEAR, ops);
            end else if (pick < 98) begin
                if ($urandom_range(0, 1) != 0) ops[23:8] = addr_ptr;
                send_item(REQ_BYTE, ops);
            end else begin
                send_item(3'($urandom_range(REQ_RESERVED_LO, REQ_RESERVED_HI)), ops);
            end
        end
    endtask

    task automatic test_random_playback();
        configure(1'b1, 1'b1, 4'd15, 8'd0, 8'd0);
        run_playback(200);
        configure(1'b1, 1'b0, 4'd14, 8'($urandom_range(0, 255)), 8'd1);
        run_playback(80);
        configure(1'b0, 1'b0, 4'd0, 8'd255, 8'd255);
        run_playback(30);
        configure(1'b1, 1'b1, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 2)));
        run_playback(60);
    endtask

    // Result side: random stalls, with bursts of none.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold = 0;
        end else if (m_axis_tready && m_axis_tvalid) begin
            rx_hold = draw_idle();
            if (rx_hold != 0) m_axis_tready <= 1'b0;
        end else if (!m_axis_tready) begin
            if (rx_hold <= 1) m_axis_tready <= 1'b1;
            else rx_hold = rx_hold - 1;
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Compare every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result item 0x%0h arrived with no prediction pending", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                seen = m_axis_tdata[26:0];
                check_field("level", 16'(want.level), 16'(seen.level));
                check_field("irq", 16'(want.irq), 16'(seen.irq));
                check_field("active", 16'(want.active), 16'(seen.active));
                check_field("fetch_req", 16'(want.fetch_req), 16'(seen.fetch_req));
                check_field("fetch_req_addr", want.fetch_req_addr, seen.fetch_req_addr);
                check_field("fetch_is_reload", 16'(want.fetch_is_reload),
                            16'(seen.fetch_is_reload));
                check_field("pad", 16'd0, 16'(m_axis_tdata[31:27]));
            end
        end
    end

    initial begin
        reset_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_requests();
        test_interrupt_flag();
        test_address_wrap();
        test_random_playback();
        wait_channel_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
